FILE: hdl/modbus_rtu_slave_frame_engine_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the frame engine modules
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define MRSFE_CHECK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define MRSFE_CHECK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mrsfe_pkg.sv
// ----------------------------------------------------------------------------
// mrsfe_pkg
// Shared types, constants and the CRC-16/MODBUS byte step of the frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrsfe_pkg;

    localparam int HOLD_REGS   = 64;
    localparam int INPUT_REGS  = 64;
    localparam int FRAME_BYTES = 256;

    localparam logic [7:0]  ADDR_RESET   = 8'd22;
    localparam logic [7:0]  ADDR_BCAST   = 8'h00;
    localparam logic [7:0]  EXC_FLAG     = 8'h80;
    localparam logic [15:0] MAX_COUNT    = 16'h007B;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // Function codes
    localparam logic [7:0] FC_READ_COILS     = 8'd1;
    localparam logic [7:0] FC_LAST_SIMPLE    = 8'd6;
    localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT     = 8'd4;
    localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
    localparam logic [7:0] FC_WRITE_HOLDING  = 8'd16;

    // Input item kinds
    typedef enum logic [1:0] {
        CMD_RX_BYTE    = 2'd0,
        CMD_BUS_RESET  = 2'd1,
        CMD_LOAD_INPUT = 2'd2,
        CMD_PULL       = 2'd3
    } cmd_t;

    // Work kinds passed from the front to the back
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_SERVE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_PULL  = 2'd3
    } op_kind_t;

    // Exception codes
    typedef enum logic [1:0] {
        EXC_NONE             = 2'd0,
        EXC_ILLEGAL_FUNCTION = 2'd1,
        EXC_ILLEGAL_ADDRESS  = 2'd2,
        EXC_ILLEGAL_VALUE    = 2'd3
    } exc_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  fc;
        logic [15:0] start;
        logic [15:0] count;
        logic        unicast;
        logic [7:0]  idx;
        logic [15:0] data;
    } op_t;

    // Advance a CRC-16/MODBUS by one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/modbus_rtu_slave_frame_engine.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine
// Modbus RTU slave: frame reception, CRC check, register service and reply.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one item per transfer: s_tuser is the command (received
//   byte, bus reset, input register load, reply pull), s_tdata its operands.
//   Only a pull produces a transfer on the m_ channel: m_tdata is the reply
//   byte, m_tuser flags that a byte was pending, m_tlast marks the final byte.
//   cfg_wr_en/cfg_wr_data set the station address; write it only while idle.
// Flow:
//   The front takes one item per cycle while its two-entry queue has room; a
//   bus reset ends there. The back stores a byte or load as it pops it; a
//   pull's result goes through the queue, the S_PULL_OUT state and the
//   output register. A frame holds the back through its register, header
//   and CRC states; the queue fills and s_tready drops meanwhile.
// Reset:
//   aresetn (synchronous, low) empties reception and the queue, drops any
//   pending reply, and makes all registers read as zero. No clearing pass.
//   A stalled m_ receiver holds the result register; pulls wait behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_slave_frame_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,  // slave_address
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,      // rx_byte[7:0], reg_index[13:8], reg_value[29:14]
    input  wire logic [1:0]  s_tuser,      // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,      // tx_byte[7:0]
    output logic             m_tuser,      // tx_valid
    output logic             m_tlast
);

    logic [7:0]     slave_address_reg;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    mrsfe_pkg::op_t q_op;
    mrsfe_pkg::op_t q_head;

    // Hold the station address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= mrsfe_pkg::ADDR_RESET;
        end else if (cfg_wr_en) begin
            slave_address_reg <= cfg_wr_data;
        end
    end

    mrsfe_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slave_address (slave_address_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .q_push        (q_push),
        .q_op          (q_op),
        .q_full        (q_full)
    );

    mrsfe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (q_op),
        .full    (q_full),
        .pop     (q_pop),
        .head_op (q_head),
        .empty   (q_empty)
    );

    mrsfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slave_address (slave_address_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hdl/mrsfe_queue.sv
// ----------------------------------------------------------------------------
// mrsfe_queue
// Two-entry work queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_slave_frame_engine_defines.svh"

module mrsfe_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  mrsfe_pkg::op_t     push_op,
    output logic               full,
    input  wire logic          pop,
    output mrsfe_pkg::op_t     head_op,
    output logic               empty
);

    mrsfe_pkg::op_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign head_op = slot_reg[rd_ptr_reg];

    // Store pushed work
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    `MRSFE_CHECK(a_no_push_full, aclk, aresetn, !(push && full), "push into full queue")
    `MRSFE_CHECK(a_no_pop_empty, aclk, aresetn, !(pop && empty), "pop from empty queue")

endmodule

`default_nettype wire

FILE: hdl/mrsfe_front.sv
// ----------------------------------------------------------------------------
// mrsfe_front
// Accepts input items, tracks frame reception and CRC, and classifies work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_slave_frame_engine_defines.svh"

module mrsfe_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  slave_address,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // rx_byte, reg_index, reg_value, zero fill
    input  wire logic [1:0]  s_tuser,   // cmd
    output logic             q_push,
    output mrsfe_pkg::op_t   q_op,
    input  wire logic        q_full
);

    mrsfe_pkg::cmd_t cmd;
    logic [7:0]      rx_byte;
    logic [5:0]      reg_index;
    logic [15:0]     reg_value;
    logic            accept;

    logic [8:0]  cnt_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  fc_reg;
    logic [15:0] start_reg;
    logic [15:0] count_reg;
    logic [15:0] crc_c_reg;
    logic [15:0] crc_b_reg;
    logic [7:0]  last_reg;

    logic [8:0]  cnt_next;
    logic [16:0] coil_sum;
    logic [17:0] total;
    logic        addr_ok;
    logic        frame_ok;
    logic        want_push;

    assign cmd       = mrsfe_pkg::cmd_t'(s_tuser);
    assign rx_byte   = s_tdata[7:0];
    assign reg_index = s_tdata[13:8];
    assign reg_value = s_tdata[29:14];
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cnt_next  = cnt_reg + 9'd1;
    assign coil_sum  = {1'b0, count_reg} + 17'd7;
    assign addr_ok   = (addr_reg == slave_address) || (addr_reg == mrsfe_pkg::ADDR_BCAST);

    // Expected frame length from the function code
    always_comb begin
        if (fc_reg >= mrsfe_pkg::FC_READ_COILS && fc_reg <= mrsfe_pkg::FC_LAST_SIMPLE) begin
            total = 18'd8;
        end else if (fc_reg == mrsfe_pkg::FC_WRITE_COILS) begin
            total = 18'd9 + {4'b0, coil_sum[16:3]};
        end else if (fc_reg == mrsfe_pkg::FC_WRITE_HOLDING) begin
            total = 18'd9 + {1'b0, count_reg, 1'b0};
        end else begin
            total = 18'd0;
        end
    end

    // Frame complete, addressed to us or broadcast, and CRC matches
    assign frame_ok = (cnt_next >= 9'd8) && addr_ok && (total != 18'd0) &&
                      (total == {9'b0, cnt_next}) &&
                      (crc_b_reg[7:0] == last_reg) && (crc_b_reg[15:8] == rx_byte);

    // Classify the item into queue work
    always_comb begin
        q_op      = '0;
        want_push = 1'b0;
        unique case (cmd)
            mrsfe_pkg::CMD_RX_BYTE: begin
                if (!cnt_reg[8]) begin
                    want_push = 1'b1;
                    if (frame_ok) begin
                        q_op.kind    = mrsfe_pkg::OP_SERVE;
                        q_op.fc      = fc_reg;
                        q_op.start   = start_reg;
                        q_op.count   = count_reg;
                        q_op.unicast = (addr_reg != mrsfe_pkg::ADDR_BCAST);
                    end else begin
                        q_op.kind = mrsfe_pkg::OP_BYTE;
                        q_op.idx  = cnt_reg[7:0];
                        q_op.data = {8'h00, rx_byte};
                    end
                end
            end
            mrsfe_pkg::CMD_BUS_RESET: begin
                want_push = 1'b0;
            end
            mrsfe_pkg::CMD_LOAD_INPUT: begin
                want_push = 1'b1;
                q_op.kind = mrsfe_pkg::OP_LOAD;
                q_op.idx  = {2'b00, reg_index};
                q_op.data = reg_value;
            end
            mrsfe_pkg::CMD_PULL: begin
                want_push = 1'b1;
                q_op.kind = mrsfe_pkg::OP_PULL;
            end
            default: begin
                want_push = 1'b0;
            end
        endcase
    end

    assign q_push = accept && want_push;

    // Capture header bytes as they arrive
    always_ff @(posedge aclk) begin
        if (accept && cmd == mrsfe_pkg::CMD_RX_BYTE && !cnt_reg[8]) begin
            case (cnt_reg)
                9'd0:    addr_reg         <= rx_byte;
                9'd1:    fc_reg           <= rx_byte;
                9'd2:    start_reg[15:8]  <= rx_byte;
                9'd3:    start_reg[7:0]   <= rx_byte;
                9'd4:    count_reg[15:8]  <= rx_byte;
                9'd5:    count_reg[7:0]   <= rx_byte;
                default: ;
            endcase
            last_reg  <= rx_byte;
            crc_b_reg <= crc_c_reg;
        end
    end

    // Track fill count and running CRC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 9'd0;
            crc_c_reg <= mrsfe_pkg::CRC_INIT;
        end else if (accept) begin
            if (cmd == mrsfe_pkg::CMD_BUS_RESET) begin
                cnt_reg   <= 9'd0;
                crc_c_reg <= mrsfe_pkg::CRC_INIT;
            end else if (cmd == mrsfe_pkg::CMD_RX_BYTE) begin
                if (cnt_reg[8] || frame_ok) begin
                    cnt_reg   <= 9'd0;
                    crc_c_reg <= mrsfe_pkg::CRC_INIT;
                end else begin
                    cnt_reg   <= cnt_next;
                    crc_c_reg <= mrsfe_pkg::crc16_byte(crc_c_reg, rx_byte);
                end
            end
        end
    end

    `MRSFE_CHECK(a_cnt_bound, aclk, aresetn, cnt_reg <= 9'd256, "frame count beyond store")
    `MRSFE_CHECK_NEXT(a_serve_clears, aclk, aresetn,
        q_push && q_op.kind == mrsfe_pkg::OP_SERVE, cnt_reg == 9'd0,
        "reception not cleared after accepted frame")

endmodule

`default_nettype wire

FILE: hdl/mrsfe_back.sv
// ----------------------------------------------------------------------------
// mrsfe_back
// Executes queued work: frame and register stores, reply building and pulls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_slave_frame_engine_defines.svh"

module mrsfe_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  slave_address,
    input  wire logic        q_empty,
    input  mrsfe_pkg::op_t   q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // tx_byte
    output logic             m_tuser,   // tx_valid
    output logic             m_tlast
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_PULL_OUT = 10'b0000000010,
        S_WR_RD    = 10'b0000000100,
        S_WR_WR    = 10'b0000001000,
        S_HDR      = 10'b0000010000,
        S_RD_REG   = 10'b0000100000,
        S_RD_HI    = 10'b0001000000,
        S_RD_LO    = 10'b0010000000,
        S_CRC_LO   = 10'b0100000000,
        S_CRC_HI   = 10'b1000000000
    } state_t;

    state_t state_reg;

    // Stores
    logic [7:0]  frame_mem [mrsfe_pkg::FRAME_BYTES];
    logic [15:0] hold_mem  [mrsfe_pkg::HOLD_REGS];
    logic [15:0] input_mem [mrsfe_pkg::INPUT_REGS];
    logic [7:0]  reply_mem [256];
    logic [mrsfe_pkg::HOLD_REGS-1:0]  hvalid_reg;
    logic [mrsfe_pkg::INPUT_REGS-1:0] ivalid_reg;

    // Registered read data
    logic [7:0]  frame_a_reg;
    logic [7:0]  frame_b_reg;
    logic [15:0] hold_rd_reg;
    logic        hold_v_reg;
    logic [15:0] input_rd_reg;
    logic        input_v_reg;
    logic [7:0]  reply_rd_reg;

    // Serve context
    mrsfe_pkg::exc_t exc_reg;
    logic [7:0]  fc_reg;
    logic [15:0] start_reg;
    logic [15:0] count_reg;
    logic        uni_reg;
    logic [6:0]  i_reg;
    logic [2:0]  hdr_idx_reg;
    logic [7:0]  wptr_reg;
    logic [15:0] crc_reg;

    // Reply pointers and output register
    logic [7:0]  rep_len_reg;
    logic [7:0]  rep_pos_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    mrsfe_pkg::exc_t exc_c;
    logic [16:0] range_sum;
    logic [16:0] range_limit;
    logic [7:0]  frame_addr_a;
    logic [7:0]  frame_addr_b;
    logic [5:0]  reg_addr;
    logic [7:0]  hdr_byte;
    logic        hdr_last;
    logic [15:0] rd_val;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        out_free;
    logic        idle_take;
    logic        count_done;

    assign idle_take   = (state_reg == S_IDLE) && !q_empty;
    assign q_pop       = idle_take;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign frame_addr_a = 8'd7 + {i_reg, 1'b0};
    assign frame_addr_b = 8'd8 + {i_reg, 1'b0};
    assign reg_addr     = start_reg[5:0] + i_reg[5:0];
    assign count_done   = ((i_reg + 7'd1) == count_reg[6:0]);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Check a serve request: function, count, then address range
    assign range_sum   = {1'b0, q_head.start} + {1'b0, q_head.count};
    assign range_limit = (q_head.fc == mrsfe_pkg::FC_READ_INPUT) ?
                         17'(mrsfe_pkg::INPUT_REGS) : 17'(mrsfe_pkg::HOLD_REGS);
    always_comb begin
        if (q_head.fc != mrsfe_pkg::FC_READ_HOLDING && q_head.fc != mrsfe_pkg::FC_READ_INPUT &&
            q_head.fc != mrsfe_pkg::FC_WRITE_HOLDING) begin
            exc_c = mrsfe_pkg::EXC_ILLEGAL_FUNCTION;
        end else if (q_head.count == 16'd0 || q_head.count > mrsfe_pkg::MAX_COUNT) begin
            exc_c = mrsfe_pkg::EXC_ILLEGAL_VALUE;
        end else if (range_sum > range_limit) begin
            exc_c = mrsfe_pkg::EXC_ILLEGAL_ADDRESS;
        end else begin
            exc_c = mrsfe_pkg::EXC_NONE;
        end
    end

    // Reply header bytes
    always_comb begin
        case (hdr_idx_reg)
            3'd0: hdr_byte = slave_address;
            3'd1: hdr_byte = (exc_reg != mrsfe_pkg::EXC_NONE) ? (fc_reg + mrsfe_pkg::EXC_FLAG)
                                                              : fc_reg;
            3'd2: begin
                if (exc_reg != mrsfe_pkg::EXC_NONE) begin
                    hdr_byte = {6'b0, exc_reg};
                end else if (fc_reg == mrsfe_pkg::FC_WRITE_HOLDING) begin
                    hdr_byte = start_reg[15:8];
                end else begin
                    hdr_byte = {count_reg[6:0], 1'b0};
                end
            end
            3'd3:    hdr_byte = start_reg[7:0];
            3'd4:    hdr_byte = count_reg[15:8];
            3'd5:    hdr_byte = count_reg[7:0];
            default: hdr_byte = 8'h00;
        endcase
        if (exc_reg != mrsfe_pkg::EXC_NONE || fc_reg != mrsfe_pkg::FC_WRITE_HOLDING) begin
            hdr_last = (hdr_idx_reg == 3'd2);
        end else begin
            hdr_last = (hdr_idx_reg == 3'd5);
        end
    end

    // Register value read for a reply; never-written entries read as zero
    assign rd_val = (fc_reg == mrsfe_pkg::FC_READ_HOLDING) ?
                    (hold_v_reg ? hold_rd_reg : 16'h0000) :
                    (input_v_reg ? input_rd_reg : 16'h0000);

    // Select the reply byte written this cycle
    always_comb begin
        wr_en   = 1'b1;
        wr_byte = 8'h00;
        unique case (state_reg)
            S_HDR:    wr_byte = hdr_byte;
            S_RD_HI:  wr_byte = rd_val[15:8];
            S_RD_LO:  wr_byte = rd_val[7:0];
            S_CRC_LO: wr_byte = crc_reg[7:0];
            S_CRC_HI: wr_byte = crc_reg[15:8];
            default:  wr_en   = 1'b0;
        endcase
    end

    // Frame store: write received bytes, read a register's two data bytes
    always_ff @(posedge aclk) begin
        if (idle_take && q_head.kind == mrsfe_pkg::OP_BYTE) begin
            frame_mem[q_head.idx] <= q_head.data[7:0];
        end
        frame_a_reg <= frame_mem[frame_addr_a];
        frame_b_reg <= frame_mem[frame_addr_b];
    end

    // Holding store
    always_ff @(posedge aclk) begin
        if (state_reg == S_WR_WR) begin
            hold_mem[reg_addr] <= {frame_a_reg, frame_b_reg};
        end
        hold_rd_reg <= hold_mem[reg_addr];
        hold_v_reg  <= hvalid_reg[reg_addr];
    end

    // Input store
    always_ff @(posedge aclk) begin
        if (idle_take && q_head.kind == mrsfe_pkg::OP_LOAD) begin
            input_mem[q_head.idx[5:0]] <= q_head.data;
        end
        input_rd_reg <= input_mem[reg_addr];
        input_v_reg  <= ivalid_reg[reg_addr];
    end

    // Reply store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            reply_mem[wptr_reg] <= wr_byte;
        end
        reply_rd_reg <= reply_mem[rep_pos_reg];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            hvalid_reg   <= '0;
            ivalid_reg   <= '0;
            rep_len_reg  <= 8'd0;
            rep_pos_reg  <= 8'd0;
            m_tvalid_reg <= 1'b0;
            exc_reg      <= mrsfe_pkg::EXC_NONE;
            i_reg        <= 7'd0;
            hdr_idx_reg  <= 3'd0;
            wptr_reg     <= 8'd0;
            crc_reg      <= mrsfe_pkg::CRC_INIT;
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && state_reg != S_PULL_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        case (q_head.kind)
                            mrsfe_pkg::OP_LOAD: begin
                                ivalid_reg[q_head.idx[5:0]] <= 1'b1;
                            end
                            mrsfe_pkg::OP_PULL: begin
                                state_reg <= S_PULL_OUT;
                            end
                            mrsfe_pkg::OP_SERVE: begin
                                exc_reg     <= exc_c;
                                fc_reg      <= q_head.fc;
                                start_reg   <= q_head.start;
                                count_reg   <= q_head.count;
                                uni_reg     <= q_head.unicast;
                                i_reg       <= 7'd0;
                                hdr_idx_reg <= 3'd0;
                                wptr_reg    <= 8'd0;
                                crc_reg     <= mrsfe_pkg::CRC_INIT;
                                if (exc_c == mrsfe_pkg::EXC_NONE &&
                                    q_head.fc == mrsfe_pkg::FC_WRITE_HOLDING) begin
                                    state_reg <= S_WR_RD;
                                end else if (q_head.unicast) begin
                                    state_reg <= S_HDR;
                                end
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PULL_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                        if (rep_len_reg != 8'd0) begin
                            m_tdata_reg <= reply_rd_reg;
                            m_tuser_reg <= 1'b1;
                            if ((rep_pos_reg + 8'd1) == rep_len_reg) begin
                                m_tlast_reg <= 1'b1;
                                rep_len_reg <= 8'd0;
                                rep_pos_reg <= 8'd0;
                            end else begin
                                m_tlast_reg <= 1'b0;
                                rep_pos_reg <= rep_pos_reg + 8'd1;
                            end
                        end else begin
                            m_tdata_reg <= 8'h00;
                            m_tuser_reg <= 1'b0;
                            m_tlast_reg <= 1'b0;
                        end
                    end
                end
                S_WR_RD: begin
                    state_reg <= S_WR_WR;
                end
                S_WR_WR: begin
                    hvalid_reg[reg_addr] <= 1'b1;
                    i_reg <= i_reg + 7'd1;
                    if (!count_done) begin
                        state_reg <= S_WR_RD;
                    end else if (uni_reg) begin
                        state_reg <= S_HDR;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_HDR: begin
                    crc_reg     <= mrsfe_pkg::crc16_byte(crc_reg, wr_byte);
                    wptr_reg    <= wptr_reg + 8'd1;
                    hdr_idx_reg <= hdr_idx_reg + 3'd1;
                    if (hdr_last) begin
                        i_reg <= 7'd0;
                        if (exc_reg != mrsfe_pkg::EXC_NONE ||
                            fc_reg == mrsfe_pkg::FC_WRITE_HOLDING) begin
                            state_reg <= S_CRC_LO;
                        end else begin
                            state_reg <= S_RD_REG;
                        end
                    end
                end
                S_RD_REG: begin
                    state_reg <= S_RD_HI;
                end
                S_RD_HI: begin
                    crc_reg   <= mrsfe_pkg::crc16_byte(crc_reg, wr_byte);
                    wptr_reg  <= wptr_reg + 8'd1;
                    state_reg <= S_RD_LO;
                end
                S_RD_LO: begin
                    crc_reg  <= mrsfe_pkg::crc16_byte(crc_reg, wr_byte);
                    wptr_reg <= wptr_reg + 8'd1;
                    i_reg    <= i_reg + 7'd1;
                    state_reg <= count_done ? S_CRC_LO : S_RD_REG;
                end
                S_CRC_LO: begin
                    wptr_reg  <= wptr_reg + 8'd1;
                    state_reg <= S_CRC_HI;
                end
                S_CRC_HI: begin
                    rep_len_reg <= wptr_reg + 8'd1;
                    rep_pos_reg <= 8'd0;
                    state_reg   <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MRSFE_CHECK(a_pos_in_reply, aclk, aresetn,
        (rep_len_reg == 8'd0) ? (rep_pos_reg == 8'd0) : (rep_pos_reg < rep_len_reg),
        "reply position outside reply")
    `MRSFE_CHECK(a_result_from_pull, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg == S_PULL_OUT),
        "result shown without a pull")

endmodule

`default_nettype wire
